/* rtl/ncpm_pkg.sv */
// Shared constants, types and a helper function of the nearest color pool matcher.
package ncpm_pkg;

	localparam int POOL_DEPTH  = 1024;
	localparam int ADDR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int SQ_W        = 2 * CHAN_W;
	localparam int DIST_W      = SQ_W + 2;
	localparam int POOL_LEFT_W = 11;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_MATCH = 2'd2;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_MATCHED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [1:0] STATUS_FULL    = 2'd3;

	typedef struct packed {
		logic       take;
		logic       clear;
		logic       load;
		logic       scan_start;
		logic       scan_rd;
		logic       rd_last;
		logic       move;
		logic       result;
		logic [1:0] status_code;
	} ncpm_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       empty;
		logic       full;
		logic       scan_end;
		logic       pipe_busy;
		logic       out_busy;
	} ncpm_stat_t;

	function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] diff;
		diff = (a > b) ? (a - b) : (b - a);
		return SQ_W'(diff) * SQ_W'(diff);
	endfunction

endpackage

/* rtl/ncpm_ifs.sv */
// Valid/ready stream interfaces for pool items and match results.
interface ncpm_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [ncpm_pkg::CHAN_W-1:0]   red;
	logic [ncpm_pkg::CHAN_W-1:0]   green;
	logic [ncpm_pkg::CHAN_W-1:0]   blue;

	modport source(output valid, func, red, green, blue, input ready);
	modport sink(input valid, func, red, green, blue, output ready);
endinterface

interface ncpm_result_if;
	logic                             valid;
	logic                             ready;
	logic [ncpm_pkg::CHAN_W-1:0]      match_red;
	logic [ncpm_pkg::CHAN_W-1:0]      match_green;
	logic [ncpm_pkg::CHAN_W-1:0]      match_blue;
	logic [1:0]                       status;
	logic [ncpm_pkg::POOL_LEFT_W-1:0] pool_left;

	modport source(output valid, match_red, match_green, match_blue, status, pool_left,
		input ready);
	modport sink(input valid, match_red, match_green, match_blue, status, pool_left,
		output ready);
endinterface

/* rtl/ncpm_ram.sv */
// Generic single-port RAM with registered read data.
module ncpm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic                                     we,
	input  logic [WIDTH-1:0]                         wr_data,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end

endmodule

/* rtl/ncpm_ctrl.sv */
// Controller state machine: sequences clear, load and match scan commands.
module ncpm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ncpm_pkg::ncpm_stat_t stat,
	output ncpm_pkg::ncpm_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_LAST,
		S_MOVE,
		S_RESULT
	} state_t;

	state_t     state_q;
	logic [1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ncpm_pkg::STATUS_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q  <= S_RESULT;
					status_q <= ncpm_pkg::STATUS_DONE;
					case (stat.func)
						ncpm_pkg::FUNC_LOAD: begin
							if (stat.full) begin
								status_q <= ncpm_pkg::STATUS_FULL;
							end
						end
						ncpm_pkg::FUNC_MATCH: begin
							if (stat.empty) begin
								status_q <= ncpm_pkg::STATUS_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (stat.scan_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					state_q  <= S_RESULT;
					status_q <= ncpm_pkg::STATUS_MATCHED;
				end
				S_RESULT: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.status_code = status_q;
		cmd.take        = (state_q == S_IDLE) && in_valid;
		cmd.clear       = (state_q == S_EXEC) && (stat.func == ncpm_pkg::FUNC_CLEAR);
		cmd.load        = (state_q == S_EXEC) && (stat.func == ncpm_pkg::FUNC_LOAD)
			&& !stat.full;
		cmd.scan_start  = (state_q == S_EXEC) && (stat.func == ncpm_pkg::FUNC_MATCH)
			&& !stat.empty;
		cmd.scan_rd     = (state_q == S_SCAN);
		cmd.rd_last     = (state_q == S_LAST);
		cmd.move        = (state_q == S_MOVE);
		cmd.result      = (state_q == S_RESULT) && !stat.out_busy;
	end

endmodule

/* rtl/ncpm_datapath.sv */
// Datapath: pool RAM, pool count, distance pipeline, best tracker and result register.
module ncpm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ncpm_pkg::ncpm_cmd_t                 cmd,
	output ncpm_pkg::ncpm_stat_t                stat,
	input  logic [1:0]                          func,
	input  logic [ncpm_pkg::CHAN_W-1:0]         red,
	input  logic [ncpm_pkg::CHAN_W-1:0]         green,
	input  logic [ncpm_pkg::CHAN_W-1:0]         blue,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ncpm_pkg::CHAN_W-1:0]         match_red,
	output logic [ncpm_pkg::CHAN_W-1:0]         match_green,
	output logic [ncpm_pkg::CHAN_W-1:0]         match_blue,
	output logic [1:0]                          status,
	output logic [ncpm_pkg::POOL_LEFT_W-1:0]    pool_left
);

	localparam int AW = ncpm_pkg::ADDR_W;
	localparam int CW = ncpm_pkg::CNT_W;
	localparam int PW = ncpm_pkg::PIX_W;
	localparam int HW = ncpm_pkg::CHAN_W;

	logic [CW-1:0]   count_q;
	logic [1:0]      func_q;
	logic [HW-1:0]   red_q, green_q, blue_q;
	logic [AW-1:0]   idx_q;

	logic            val_s1, val_s2;
	logic [AW-1:0]   idx_s1, idx_s2;
	logic [PW-1:0]   pix_s2;
	logic [ncpm_pkg::SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;

	logic [ncpm_pkg::DIST_W-1:0] dist_sum;
	logic [ncpm_pkg::DIST_W-1:0] best_d_q;
	logic [AW-1:0]   best_idx_q;
	logic [PW-1:0]   best_pix_q;

	logic            out_valid_q;
	logic [HW-1:0]   match_red_q, match_green_q, match_blue_q;
	logic [1:0]      status_q;
	logic [ncpm_pkg::POOL_LEFT_W-1:0] pool_left_q;

	logic [AW-1:0]   ram_addr;
	logic            ram_we;
	logic [PW-1:0]   ram_wdata;
	logic [PW-1:0]   ram_rdata;
	logic [CW-1:0]   last_slot;

	assign last_slot = count_q - CW'(1);

	always_comb begin
		ram_addr  = idx_q;
		ram_we    = 1'b0;
		ram_wdata = {red_q, green_q, blue_q};
		if (cmd.load) begin
			ram_addr = count_q[AW-1:0];
			ram_we   = 1'b1;
		end else if (cmd.rd_last) begin
			ram_addr = last_slot[AW-1:0];
		end else if (cmd.move) begin
			// fill the hole left by the winner with the last entry
			ram_addr  = best_idx_q;
			ram_we    = 1'b1;
			ram_wdata = ram_rdata;
		end
	end

	ncpm_ram #(
		.WIDTH(PW),
		.DEPTH(ncpm_pkg::POOL_DEPTH)
	) u_pool_ram (
		.clk    (clk),
		.addr   (ram_addr),
		.we     (ram_we),
		.wr_data(ram_wdata),
		.rd_data(ram_rdata)
	);

	assign dist_sum = ncpm_pkg::DIST_W'(sq_r_s2) + ncpm_pkg::DIST_W'(sq_g_s2)
		+ ncpm_pkg::DIST_W'(sq_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			val_s1      <= 1'b0;
			val_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.load) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.move) begin
				count_q <= last_slot;
			end
			val_s1 <= cmd.scan_rd;
			val_s2 <= val_s1;
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q  <= func;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_rd) begin
			idx_q <= idx_q + AW'(1);
		end
		idx_s1  <= idx_q;
		idx_s2  <= idx_s1;
		pix_s2  <= ram_rdata;
		sq_r_s2 <= ncpm_pkg::chan_sq(ram_rdata[PW-1 -: HW], red_q);
		sq_g_s2 <= ncpm_pkg::chan_sq(ram_rdata[2*HW-1 -: HW], green_q);
		sq_b_s2 <= ncpm_pkg::chan_sq(ram_rdata[HW-1:0], blue_q);
		// slot zero seeds the minimum, later slots replace it only when strictly closer
		if (val_s2 && ((idx_s2 == '0) || (dist_sum < best_d_q))) begin
			best_d_q   <= dist_sum;
			best_idx_q <= idx_s2;
			best_pix_q <= pix_s2;
		end
		if (cmd.result) begin
			status_q    <= cmd.status_code;
			pool_left_q <= ncpm_pkg::POOL_LEFT_W'(count_q);
			if (cmd.status_code == ncpm_pkg::STATUS_MATCHED) begin
				match_red_q   <= best_pix_q[PW-1 -: HW];
				match_green_q <= best_pix_q[2*HW-1 -: HW];
				match_blue_q  <= best_pix_q[HW-1:0];
			end else begin
				match_red_q   <= '0;
				match_green_q <= '0;
				match_blue_q  <= '0;
			end
		end
	end

	assign stat.func      = func_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= CW'(ncpm_pkg::POOL_DEPTH));
	assign stat.scan_end  = (CW'(idx_q) == last_slot);
	assign stat.pipe_busy = val_s1 | val_s2;
	assign stat.out_busy  = out_valid_q & ~out_ready;

	assign out_valid   = out_valid_q;
	assign match_red   = match_red_q;
	assign match_green = match_green_q;
	assign match_blue  = match_blue_q;
	assign status      = status_q;
	assign pool_left   = pool_left_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ncpm_pkg::POOL_DEPTH))
		else $error("pool count above depth");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> !(out_valid_q && !out_ready))
		else $error("result loaded over a pending transfer");

	a_scan_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (CW'(idx_q) < count_q))
		else $error("scan read beyond occupied slots");

	a_move_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (CW'(best_idx_q) < count_q) && !val_s1 && !val_s2)
		else $error("move with stale or out-of-range winner");

endmodule

/* rtl/nearest_color_pool_matcher_top.sv */
// Top level of the nearest color pool matcher: controller plus datapath.
//
// Channels: item (sink) carries func, red, green, blue; result (source) carries
// match_red, match_green, match_blue, status and pool_left. A transfer happens
// on a rising edge with valid and ready both high. Every item gives one result.
// One item is processed at a time; item.ready is high only while the block is
// idle, so it does take the next item while an earlier result waits in the
// output register.
// From item transfer to result valid: clear, load and match on an empty pool go
// from the execute state straight to the result state; a match over a non-empty
// pool first runs the scan, which reads one pool slot per cycle through
// the single RAM port and then drains the two-stage distance pipeline before the
// last entry is read and written into the winner's slot.
// The next item can be taken in the cycle after a result loads.
// Reset empties the pool at once (count cleared); RAM contents are not cleared.
// When the receiver stalls, the result register holds its value, and a finished
// item waits in its last state until the register frees.
module nearest_color_pool_matcher_top (
	input  logic           clk,
	input  logic           arst_n,
	ncpm_item_if.sink      item,
	ncpm_result_if.source  result
);

	ncpm_pkg::ncpm_cmd_t  cmd;
	ncpm_pkg::ncpm_stat_t stat;

	ncpm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ncpm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (item.func),
		.red        (item.red),
		.green      (item.green),
		.blue       (item.blue),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.match_red  (result.match_red),
		.match_green(result.match_green),
		.match_blue (result.match_blue),
		.status     (result.status),
		.pool_left  (result.pool_left)
	);

endmodule
